FILE: src/lzfbd_pkg.sv
// Shared types and constants for the LZSS flag-byte decompressor.
package lzfbd_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned COUNT_W   = 24;
	localparam int unsigned LEN_W     = 5;
	localparam int unsigned DIST_W    = 12;
	localparam int unsigned FLAGCNT_W = 4;

	localparam logic [FLAGCNT_W-1:0] FLAGS_PER_BYTE = 4'd8;
	localparam logic [LEN_W-1:0]     LEN_BIAS       = 5'd2;
	localparam logic [DIST_W-1:0]    DIST_BIAS      = 12'd1;
	localparam logic [COUNT_W-1:0]   OUT_LEN_RESET  = 24'd1;

	typedef struct packed {
		logic [BYTE_W-1:0] in_byte;
		logic              start_item;
	} in_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              run_last;
		logic              item_done;
		logic              status;
	} out_item_t;

	typedef enum logic [1:0] {
		TOK_NONE,
		TOK_LIT,
		TOK_COPY
	} tok_kind_t;

	typedef struct packed {
		logic capture;
		logic decode;
		logic lit_emit;
		logic copy_rd;
		logic copy_wr;
	} ctrl_cmd_t;

	typedef struct packed {
		tok_kind_t kind;
		logic      out_free;
		logic      copy_last;
	} dp_status_t;

endpackage

FILE: src/lzfbd_ctrl.sv
// Controller state machine: sequences accept, decode, literal and copy steps.
module lzfbd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  lzfbd_pkg::dp_status_t sts,
	output lzfbd_pkg::ctrl_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_LIT,
		ST_CRD,
		ST_CWR
	} state_t;

	state_t state_q;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.capture  = in_valid && (state_q == ST_IDLE);
		cmd.decode   = (state_q == ST_DECODE);
		cmd.lit_emit = (state_q == ST_LIT) && sts.out_free;
		cmd.copy_rd  = (state_q == ST_CRD);
		cmd.copy_wr  = (state_q == ST_CWR) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_DECODE;
				end
				ST_DECODE: begin
					unique case (sts.kind)
						lzfbd_pkg::TOK_LIT:  state_q <= ST_LIT;
						lzfbd_pkg::TOK_COPY: state_q <= ST_CRD;
						default:             state_q <= ST_IDLE;
					endcase
				end
				ST_LIT: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				ST_CRD: begin
					state_q <= ST_CWR;
				end
				ST_CWR: begin
					if (sts.out_free && sts.copy_last) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: src/lzfbd_dp.sv
// Datapath: token parser registers, history window, copy engine, output register.
module lzfbd_dp #(
	parameter int unsigned WINDOW_DEPTH = 4096
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lzfbd_pkg::in_item_t       in_data,
	input  logic                      cfg_wr_en,
	input  logic [lzfbd_pkg::COUNT_W-1:0] cfg_wr_data,
	input  logic                      out_stall,
	output logic                      out_valid,
	output lzfbd_pkg::out_item_t      out_data,
	input  lzfbd_pkg::ctrl_cmd_t      cmd,
	output lzfbd_pkg::dp_status_t     sts
);

	localparam int unsigned AW = $clog2(WINDOW_DEPTH);

	typedef enum logic [1:0] {
		PH_FLAG,
		PH_TOKEN,
		PH_HIGH
	} phase_t;

	// captured input transaction
	logic [lzfbd_pkg::BYTE_W-1:0]    byte_q;
	logic                            start_q;

	// parser state
	phase_t                          phase_q;
	logic [lzfbd_pkg::BYTE_W-1:0]    flag_bits_q;
	logic [lzfbd_pkg::FLAGCNT_W-1:0] flags_left_q;
	logic [lzfbd_pkg::BYTE_W-1:0]    tok_lo_q;
	logic [lzfbd_pkg::COUNT_W-1:0]   emitted_q;
	logic                            finished_q;
	logic [lzfbd_pkg::COUNT_W-1:0]   out_len_q;

	// window and copy engine
	logic [lzfbd_pkg::BYTE_W-1:0]    history_q [WINDOW_DEPTH];
	logic [AW-1:0]                   wp_q;
	logic                            wrapped_q;
	logic [AW-1:0]                   src_q;
	logic [AW-1:0]                   copy_src;
	logic [lzfbd_pkg::LEN_W-1:0]     len_left_q;
	logic                            st_q;
	logic                            fwd_q;
	logic [lzfbd_pkg::BYTE_W-1:0]    last_byte_q;
	logic [lzfbd_pkg::BYTE_W-1:0]    rd_data_s1;
	logic                            rd_ok_s1;
	logic                            fwd_s1;

	// output register
	logic                            out_valid_q;
	lzfbd_pkg::out_item_t            out_q;

	// decode view after an item start is applied
	phase_t                          eff_phase;
	logic                            eff_fin;
	logic [lzfbd_pkg::COUNT_W-1:0]   eff_emit;
	logic [lzfbd_pkg::BYTE_W-1:0]    eff_bits;
	logic [lzfbd_pkg::FLAGCNT_W-1:0] eff_left;
	logic [lzfbd_pkg::COUNT_W-1:0]   room;
	logic [lzfbd_pkg::LEN_W-1:0]     tok_len;
	logic [lzfbd_pkg::DIST_W-1:0]    tok_dist;
	logic                            len_fits;
	logic [lzfbd_pkg::LEN_W-1:0]     clip_len;
	logic [lzfbd_pkg::FLAGCNT_W-1:0] nf_left;
	phase_t                          nf_phase;
	lzfbd_pkg::tok_kind_t            kind;

	logic                            emit_en;
	logic [lzfbd_pkg::BYTE_W-1:0]    copy_byte;
	logic [lzfbd_pkg::BYTE_W-1:0]    emit_byte;
	logic                            emit_st;
	logic                            emit_last;
	logic [lzfbd_pkg::COUNT_W-1:0]   emit_count;
	logic                            emit_done;
	logic                            copy_last;
	logic                            rd_en;
	logic                            out_free;

	always_comb begin
		eff_phase = start_q ? PH_FLAG : phase_q;
		eff_fin   = start_q ? 1'b0 : finished_q;
		eff_emit  = start_q ? '0 : emitted_q;
		eff_bits  = start_q ? '0 : flag_bits_q;
		eff_left  = start_q ? '0 : flags_left_q;
		room      = (out_len_q > eff_emit) ? (out_len_q - eff_emit) : '0;
		tok_len   = {1'b0, tok_lo_q[3:0]} + lzfbd_pkg::LEN_BIAS;
		tok_dist  = {byte_q, tok_lo_q[7:4]} + lzfbd_pkg::DIST_BIAS;
		len_fits  = ({{(lzfbd_pkg::COUNT_W-lzfbd_pkg::LEN_W){1'b0}}, tok_len} <= room);
		clip_len  = len_fits ? tok_len : room[lzfbd_pkg::LEN_W-1:0];
		nf_left   = (eff_left == '0) ? '0 : eff_left - 1'b1;
		nf_phase  = (nf_left == '0) ? PH_FLAG : PH_TOKEN;
		kind      = lzfbd_pkg::TOK_NONE;
		if (!eff_fin) begin
			unique case (eff_phase)
				PH_TOKEN: begin
					if (eff_bits[0] && (room != '0)) kind = lzfbd_pkg::TOK_LIT;
				end
				PH_HIGH: begin
					if (clip_len != '0) kind = lzfbd_pkg::TOK_COPY;
				end
				default: kind = lzfbd_pkg::TOK_NONE;
			endcase
		end
	end

	// first read address of a copy, the distance behind the write pointer
	lzfbd_addr #(
		.AW (AW)
	) u_addr (
		.wp   (wp_q),
		.back (AW'(tok_dist)),
		.addr (copy_src)
	);

	assign out_free   = !out_valid_q || !out_stall;
	assign copy_last  = (len_left_q == lzfbd_pkg::LEN_W'(1));
	assign copy_byte  = fwd_s1 ? last_byte_q : (rd_ok_s1 ? rd_data_s1 : '0);
	assign emit_en    = cmd.lit_emit || cmd.copy_wr;
	assign emit_byte  = cmd.lit_emit ? byte_q : copy_byte;
	assign emit_st    = cmd.lit_emit ? 1'b0 : st_q;
	assign emit_last  = cmd.lit_emit ? 1'b1 : copy_last;
	assign emit_count = emitted_q + 1'b1;
	assign emit_done  = (emit_count == out_len_q);
	// issue the next window read alongside each copy byte but the last
	assign rd_en      = cmd.copy_rd || (cmd.copy_wr && !copy_last);

	assign sts.kind      = kind;
	assign sts.out_free  = out_free;
	assign sts.copy_last = copy_last;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// history window: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (emit_en) history_q[wp_q] <= emit_byte;
		if (rd_en)   rd_data_s1      <= history_q[src_q];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			byte_q  <= in_data.in_byte;
		end
		if (cmd.decode) begin
			src_q <= copy_src;
			fwd_q <= (tok_dist == lzfbd_pkg::DIST_BIAS);
			st_q  <= !len_fits;
		end else if (rd_en) begin
			src_q <= src_q + 1'b1;
		end
		if (rd_en) begin
			rd_ok_s1 <= wrapped_q || (src_q < wp_q);
			fwd_s1   <= cmd.copy_rd ? 1'b0 : fwd_q;
		end
		if (emit_en) begin
			last_byte_q        <= emit_byte;
			out_q.out_byte     <= emit_byte;
			out_q.run_last     <= emit_last;
			out_q.item_done    <= emit_done;
			out_q.status       <= emit_st;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q      <= 1'b0;
			phase_q      <= PH_FLAG;
			flag_bits_q  <= '0;
			flags_left_q <= '0;
			tok_lo_q     <= '0;
			emitted_q    <= '0;
			finished_q   <= 1'b0;
			out_len_q    <= lzfbd_pkg::OUT_LEN_RESET;
			wp_q         <= '0;
			wrapped_q    <= 1'b0;
			len_left_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) out_len_q <= cfg_wr_data;
			if (cmd.capture) start_q <= in_data.start_item;

			if (cmd.decode && !eff_fin) begin
				emitted_q  <= eff_emit;
				finished_q <= 1'b0;
				unique case (eff_phase)
					PH_FLAG: begin
						flag_bits_q  <= byte_q;
						flags_left_q <= lzfbd_pkg::FLAGS_PER_BYTE;
						phase_q      <= PH_TOKEN;
					end
					PH_TOKEN: begin
						if (eff_bits[0]) begin
							flag_bits_q  <= eff_bits >> 1;
							flags_left_q <= nf_left;
							phase_q      <= nf_phase;
						end else begin
							flag_bits_q  <= eff_bits;
							flags_left_q <= eff_left;
							tok_lo_q     <= byte_q;
							phase_q      <= PH_HIGH;
						end
					end
					default: begin
						flag_bits_q  <= eff_bits >> 1;
						flags_left_q <= nf_left;
						phase_q      <= nf_phase;
						len_left_q   <= clip_len;
					end
				endcase
			end

			if (emit_en) begin
				wp_q      <= wp_q + 1'b1;
				wrapped_q <= wrapped_q || (wp_q == '1);
				emitted_q <= emit_count;
				if (emit_done) finished_q <= 1'b1;
				if (cmd.copy_wr) len_left_q <= len_left_q - 1'b1;
			end

			if (emit_en) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: src/lzfbd_flag_byte_top_note.sv
// Window address helper: maps a distance to a read address behind the write pointer.
module lzfbd_addr #(
	parameter int unsigned AW = 12
) (
	input  logic [AW-1:0] wp,
	input  logic [AW-1:0] back,
	output logic [AW-1:0] addr
);

	assign addr = wp - back;

endmodule

FILE: src/lzss_flag_byte_decompressor.sv
// Top level of the LZSS flag-byte decompressor (12-bit distance, 4-bit length).
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one compressed byte per
//   transaction; set start_item on the first byte of each new item. Output channel
//   (out_valid / out_stall / out_data) carries one decompressed byte per transaction.
//   run_last marks the last byte caused by an input byte, item_done the byte that
//   reaches output_length, status a copy that was cut short at the end.
//   Write output_length through cfg_wr_en / cfg_wr_data only while the block is idle.
// Sequence:
//   A flag byte or a token's low byte passes through accept and decode; a literal adds
//   an emit step that writes it to the output register. A back-reference is decoded,
//   then starts the window read, and then the copy engine moves one byte per cycle,
//   unless the output stalls, through the single-port-read history window.
// Reset:
//   arst_n clears the parser, counters and output valid flag and sets output_length to 1.
//   Window entries not yet written since reset read as zero, tracked by the write
//   pointer and a wrap flag, so no clearing pass is needed.
// Backpressure:
//   A stalled output holds its byte; the copy engine pauses and input waits.
module lzss_flag_byte_decompressor #(
	parameter int unsigned WINDOW_DEPTH = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  lzfbd_pkg::in_item_t           in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output lzfbd_pkg::out_item_t          out_data,
	input  logic                          cfg_wr_en,
	input  logic [lzfbd_pkg::COUNT_W-1:0] cfg_wr_data
);

	// command and status between sequencer and datapath
	lzfbd_pkg::ctrl_cmd_t  cmd;
	lzfbd_pkg::dp_status_t sts;

	// sequencer: accept, decode, then emit literal or run the copy
	lzfbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// parser registers, history window and output register
	lzfbd_dp #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_data     (in_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.out_data    (out_data),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule
